// File: sv/hlva_pkg.sv
`timescale 1ns / 1ps

package hlva_pkg;

  localparam int unsigned DXY_W     = 9;
  localparam int unsigned ANG_W     = 8;
  localparam int unsigned TABLE_BITS = 14;
  localparam int unsigned OUT_CNT_W = 16;

  localparam logic OP_VOTE = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_X  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Y  = 2'd2;
  localparam int unsigned CFG_DATA_W = 16;

  // cos(5j deg), j = 0..18, Q1.14
  localparam int COS_Q14 [19] = '{
    16384, 16322, 16135, 15826, 15396, 14849, 14189, 13421, 12551, 11585,
    10531, 9397, 8192, 6924, 5604, 4240, 2845, 1428, 0
  };

  typedef struct packed {
    logic       op;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic       is_white;
    logic [5:0] angle_index;
    logic [7:0] distance_bin;
  } in_item_t;

  typedef struct packed {
    logic [15:0] bin_count;
    logic        above_threshold;
    logic [5:0]  read_angle;
    logic [7:0]  read_distance;
  } out_item_t;

  // item as it travels along the cell chain
  typedef struct packed {
    logic                    vld;
    logic                    op;
    logic signed [DXY_W-1:0] dx;
    logic signed [DXY_W-1:0] dy;
    logic [5:0]              angle;
    logic [7:0]              dist_bin;
  } link_t;

  // scaled cos or sin of angle 5k deg with frac fraction bits
  function automatic int trig_value(int unsigned k, int unsigned frac, bit want_sin);
    int unsigned j;
    bit          flip;
    int          v;
    int          mag;
    bit          neg;
    j    = k % 36;
    flip = ((k / 36) % 2) == 1;
    if (j <= 18) begin
      v = want_sin ? COS_Q14[18 - j] : COS_Q14[j];
    end else begin
      v = want_sin ? COS_Q14[j - 18] : -COS_Q14[36 - j];
    end
    if (flip) begin
      v = -v;
    end
    neg = v < 0;
    mag = neg ? -v : v;
    if (frac >= TABLE_BITS) begin
      mag = mag << (frac - TABLE_BITS);
    end else begin
      mag = (mag + (1 << (TABLE_BITS - frac - 1))) >> (TABLE_BITS - frac);
    end
    return neg ? -mag : mag;
  endfunction

endpackage

// File: sv/hough_line_vote_accumulator.sv
`timescale 1ns / 1ps
// Items pass from accept to result through the entry register, the chain
// of angle cells (three stages each: multiply, bank read, update) and the
// output register. Throughput: one item per cycle; a stalled result
// freezes the whole chain. Reset: registers with a reset go to their
// defaults, then a clearing pass zeroes all banks while the input is stalled.
module hough_line_vote_accumulator import hlva_pkg::*; #(
  parameter int unsigned ANGLE_STEPS        = 36,
  parameter int unsigned DISTANCE_BINS      = 201,
  parameter int unsigned COUNT_WIDTH        = 16,
  parameter int unsigned TRIG_FRACTION_BITS = 14
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(DISTANCE_BINS);
  localparam int unsigned EW = (COUNT_WIDTH > OUT_CNT_W) ? COUNT_WIDTH : OUT_CNT_W;

  logic [15:0]   thr_q;
  logic [7:0]    cx_q, cy_q;
  logic          clr_q;
  logic [AW-1:0] clr_addr_q;
  logic          en;
  logic          out_valid_q;
  out_item_t     out_q;
  link_t         entry_q;

  link_t                  link  [ANGLE_STEPS+1];
  logic [COUNT_WIDTH-1:0] count [ANGLE_STEPS+1];

  link_t         last;
  logic [EW-1:0] cnt_ext;

  assign en         = !clr_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 16'd90;
      cx_q  <= 8'd80;
      cy_q  <= 8'd60;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_THRESHOLD: thr_q <= cfg_data_i;
        CFG_CENTRE_X:  cx_q  <= cfg_data_i[7:0];
        CFG_CENTRE_Y:  cy_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      if (clr_addr_q == AW'(DISTANCE_BINS - 1)) begin
        clr_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  // non-white votes enter the chain only as invalid items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (en) begin
      entry_q.vld      <= in_valid_i && ((in_item_i.op == OP_READ) || in_item_i.is_white);
      entry_q.op       <= in_item_i.op;
      entry_q.dx       <= $signed({1'b0, in_item_i.pixel_x}) - $signed({1'b0, cx_q});
      entry_q.dy       <= $signed({1'b0, cy_q}) - $signed({1'b0, in_item_i.pixel_y});
      entry_q.angle    <= in_item_i.angle_index;
      entry_q.dist_bin <= in_item_i.distance_bin;
    end
  end

  assign link[0]  = entry_q;
  assign count[0] = '0;

  for (genvar k = 0; k < ANGLE_STEPS; k++) begin : g_cell
    hlva_cell #(
      .K                  (k),
      .DISTANCE_BINS      (DISTANCE_BINS),
      .COUNT_WIDTH        (COUNT_WIDTH),
      .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .clr_i      (clr_q),
      .clr_addr_i (clr_addr_q),
      .link_i     (link[k]),
      .count_i    (count[k]),
      .link_o     (link[k+1]),
      .count_o    (count[k+1])
    );
  end

  assign last    = link[ANGLE_STEPS];
  assign cnt_ext = EW'(count[ANGLE_STEPS]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= last.vld && (last.op == OP_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.bin_count       <= (cnt_ext > EW'(16'hFFFF)) ? 16'hFFFF : cnt_ext[15:0];
      out_q.above_threshold <= cnt_ext > EW'(thr_q);
      out_q.read_angle      <= last.angle;
      out_q.read_distance   <= last.dist_bin;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: sv/hlva_cell.sv
`timescale 1ns / 1ps

module hlva_cell import hlva_pkg::*; #(
  parameter int unsigned K                  = 0,
  parameter int unsigned DISTANCE_BINS      = 201,
  parameter int unsigned COUNT_WIDTH        = 16,
  parameter int unsigned TRIG_FRACTION_BITS = 14
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             clr_i,
  input  logic [$clog2(DISTANCE_BINS)-1:0] clr_addr_i,
  input  link_t                            link_i,
  input  logic [COUNT_WIDTH-1:0]           count_i,
  output link_t                            link_o,
  output logic [COUNT_WIDTH-1:0]           count_o
);

  localparam int unsigned AW   = $clog2(DISTANCE_BINS);
  localparam int unsigned XW   = ((AW > 8) ? AW : 8) + 1;
  localparam int unsigned TW   = TRIG_FRACTION_BITS + 2;
  localparam int unsigned PW   = TW + DXY_W;
  localparam int unsigned SW   = PW + 1;
  localparam int unsigned HALF = DISTANCE_BINS / 2;
  localparam logic signed [TW-1:0] COS_K = TW'(trig_value(K, TRIG_FRACTION_BITS, 1'b0));
  localparam logic signed [TW-1:0] SIN_K = TW'(trig_value(K, TRIG_FRACTION_BITS, 1'b1));
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic [COUNT_WIDTH-1:0] bank [DISTANCE_BINS];

  // stage 1: products
  link_t                  s1_q;
  logic [COUNT_WIDTH-1:0] s1_cnt_q;
  logic signed [PW-1:0]   s1_pc_q, s1_ps_q;

  // stage 2: bank access
  link_t                  s2_q;
  logic [COUNT_WIDTH-1:0] s2_cnt_q;
  logic                   s2_wr_q, s2_rd_q;
  logic [AW-1:0]          s2_addr_q;
  logic [COUNT_WIDTH-1:0] rdata_q;

  // last write, for back-to-back hits on one bin
  logic                   wr_vld_q;
  logic [AW-1:0]          wr_addr_q;
  logic [COUNT_WIDTH-1:0] wr_data_q;

  link_t                  s3_q;
  logic [COUNT_WIDTH-1:0] s3_cnt_q;

  logic signed [SW-1:0] sum, r_val, pos;
  logic        [SW-1:0] mag, r_mag;
  logic                 neg, in_rng, vote_hit, read_hit;
  logic        [XW-1:0] dist_ext;
  logic        [AW-1:0] addr;
  logic [COUNT_WIDTH-1:0] old_cnt, new_cnt;

  always_comb begin
    sum      = SW'(s1_pc_q) + SW'(s1_ps_q);
    neg      = sum[SW-1];
    mag      = neg ? SW'(-sum) : SW'(sum);
    r_mag    = mag >> TRIG_FRACTION_BITS;
    r_val    = neg ? -$signed(r_mag) : $signed(r_mag);
    pos      = r_val + SW'(HALF);
    in_rng   = !pos[SW-1] && (pos < SW'(DISTANCE_BINS));
    dist_ext = XW'(s1_q.dist_bin);
    vote_hit = s1_q.vld && (s1_q.op == OP_VOTE) && in_rng;
    read_hit = s1_q.vld && (s1_q.op == OP_READ) && (ANG_W'(s1_q.angle) == ANG_W'(K))
               && (dist_ext < XW'(DISTANCE_BINS));
    addr     = (s1_q.op == OP_VOTE) ? pos[AW-1:0] : dist_ext[AW-1:0];
  end

  always_comb begin
    old_cnt = (wr_vld_q && (wr_addr_q == s2_addr_q)) ? wr_data_q : rdata_q;
    if (s2_q.op == OP_READ) begin
      new_cnt = '0;
    end else if (old_cnt == CNT_MAX) begin
      new_cnt = old_cnt;
    end else begin
      new_cnt = old_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q      <= '0;
      s1_cnt_q  <= '0;
      s1_pc_q   <= '0;
      s1_ps_q   <= '0;
      s2_q      <= '0;
      s2_cnt_q  <= '0;
      s2_wr_q   <= 1'b0;
      s2_rd_q   <= 1'b0;
      s2_addr_q <= '0;
      wr_vld_q  <= 1'b0;
      wr_addr_q <= '0;
      wr_data_q <= '0;
      s3_q      <= '0;
      s3_cnt_q  <= '0;
    end else if (en_i) begin
      s1_q      <= link_i;
      s1_cnt_q  <= count_i;
      s1_pc_q   <= PW'(link_i.dx) * PW'(COS_K);
      s1_ps_q   <= PW'(link_i.dy) * PW'(SIN_K);

      s2_q      <= s1_q;
      s2_cnt_q  <= s1_cnt_q;
      s2_wr_q   <= vote_hit || read_hit;
      s2_rd_q   <= read_hit;
      s2_addr_q <= addr;

      wr_vld_q  <= s2_wr_q;
      wr_addr_q <= s2_addr_q;
      wr_data_q <= new_cnt;

      s3_q      <= s2_q;
      s3_cnt_q  <= s2_rd_q ? old_cnt : s2_cnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q <= bank[addr];
    end
    if (clr_i) begin
      bank[clr_addr_i] <= '0;
    end else if (en_i && s2_wr_q) begin
      bank[s2_addr_q] <= new_cnt;
    end
  end

  assign link_o  = s3_q;
  assign count_o = s3_cnt_q;

endmodule
